FILE: rtl/xrr_pkg.sv
package xrr_pkg;

    localparam int DATA_W  = 32;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 3;

    localparam logic [DATA_W-1:0] DEFAULT_SEED = 32'h1D87_2665;
    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    // Register index held in paddr bit 2
    localparam logic REG_SEED = 1'b0;

    localparam logic [CNT_W-1:0] LAST_STEP = {CNT_W{1'b1}};

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_step;
    } dp_status_t;

    // One xorshift32 step
    function automatic logic [DATA_W-1:0] xs_advance(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] y;
        begin
            y = x ^ (x << SHIFT_A);
            y = y ^ (y >> SHIFT_B);
            y = y ^ (y << SHIFT_C);
            return y;
        end
    endfunction

endpackage

FILE: rtl/xrr_req_if.sv
interface xrr_req_if;
    logic                               valid;
    logic                               ready;
    logic signed [xrr_pkg::DATA_W-1:0]  low_bound;
    logic signed [xrr_pkg::DATA_W-1:0]  high_bound;

    modport source (output valid, output low_bound, output high_bound, input ready);
    modport sink   (input valid, input low_bound, input high_bound, output ready);
endinterface

FILE: rtl/xrr_rsp_if.sv
interface xrr_rsp_if;
    logic                               valid;
    logic                               ready;
    logic        [xrr_pkg::DATA_W-1:0]  raw_word;
    logic signed [xrr_pkg::DATA_W-1:0]  ranged_value;
    logic                               range_error;

    modport source (output valid, output raw_word, output ranged_value,
                    output range_error, input ready);
    modport sink   (input valid, input raw_word, input ranged_value,
                    input range_error, output ready);
endinterface

FILE: rtl/xrr_ctrl.sv
module xrr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output xrr_pkg::dp_cmd_t    cmd,
    input  xrr_pkg::dp_status_t status
);
    import xrr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        in_take;
    logic        emit_ok;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    // Output slot is free when empty or being drained this cycle
    assign emit_ok   = !out_valid_reg || out_ready;

    // Sequence load, divide steps and emit
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set output valid on emit, drop it when the item is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/xrr_dp.sv
module xrr_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  xrr_pkg::dp_cmd_t                    cmd,
    output xrr_pkg::dp_status_t                 status,
    input  logic                                seed_load,
    input  logic        [xrr_pkg::DATA_W-1:0]   seed_word,
    input  logic signed [xrr_pkg::DATA_W-1:0]   low_bound,
    input  logic signed [xrr_pkg::DATA_W-1:0]   high_bound,
    output logic        [xrr_pkg::DATA_W-1:0]   raw_word,
    output logic signed [xrr_pkg::DATA_W-1:0]   ranged_value,
    output logic                                range_error
);
    import xrr_pkg::*;

    logic [DATA_W-1:0] gen_reg;
    logic [DATA_W-1:0] raw_reg;
    logic [DATA_W-1:0] dvd_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] span_reg;
    logic              err_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] out_raw_reg;
    logic [DATA_W-1:0] out_ranged_reg;
    logic              out_err_reg;

    logic [DATA_W-1:0] gen_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] rem_sel;

    assign gen_next = xs_advance(gen_reg);

    // One restoring divide step: shift in next dividend bit, subtract if it fits
    assign shifted  = {rem_reg, dvd_reg[DATA_W-1]};
    assign trial    = shifted - {1'b0, span_reg};
    assign rem_next = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];

    // A wrapped span of zero stands for the full 2^32 range
    assign rem_sel  = (span_reg == '0) ? raw_reg : rem_reg;

    assign status.last_step = (cnt_reg == LAST_STEP);

    // Generator state: reload from seed, advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= DEFAULT_SEED;
        end
        else if (seed_load)
        begin
            gen_reg <= (seed_word == '0) ? DEFAULT_SEED : seed_word;
        end
        else if (cmd.load)
        begin
            gen_reg <= gen_next;
        end
    end

    // Divider and operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg  <= gen_next;
            dvd_reg  <= gen_next;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            lo_reg   <= low_bound;
            span_reg <= high_bound - low_bound + DATA_W'(1);
            err_reg  <= (high_bound < low_bound);
        end
        else if (cmd.step)
        begin
            dvd_reg <= {dvd_reg[DATA_W-2:0], 1'b0};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_raw_reg    <= raw_reg;
            out_ranged_reg <= err_reg ? lo_reg : (lo_reg + rem_sel);
            out_err_reg    <= err_reg;
        end
    end

    assign raw_word     = out_raw_reg;
    assign ranged_value = out_ranged_reg;
    assign range_error  = out_err_reg;

endmodule

FILE: rtl/xorshift_ranged_random.sv
// Ranged xorshift32 random number source.
// Input channel req carries a draw request with signed inclusive bounds
// low_bound and high_bound. Output channel rsp returns the new generator word
// raw_word, ranged_value = low_bound + raw_word mod (high_bound-low_bound+1),
// and range_error, set when high_bound < low_bound (ranged_value is then
// low_bound; the generator still advances).
// Timing: the accepting edge loads the operands and advances the generator,
// then a restoring divider forms one remainder bit per cycle, then an emit
// cycle sets rsp.valid once the output register is free. The next request
// is taken the cycle after the emit, so the divider serves one request at
// a time.
// A finished result sits in the output register; the next request is taken
// while it waits, and a stalled receiver only holds up the emit of the
// following item until the register is drained.
// Reset (rst_n low, asynchronous) loads the default seed 0x1D872665 and
// empties the output. An APB write to the seed register (address 0) reloads
// the generator; a zero seed loads the default instead. Write only when idle.
module xorshift_ranged_random (
    input  logic                        clk,
    input  logic                        rst_n,
    xrr_req_if.sink                     req,
    xrr_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xrr_pkg::ADDR_W-1:0]  paddr,
    input  logic [xrr_pkg::DATA_W-1:0]  pwdata,
    output logic [xrr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import xrr_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [DATA_W-1:0] seed_reg;
    logic              wr_en;
    logic              seed_load;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign seed_load = wr_en && (paddr[2] == REG_SEED);

    // Seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= DEFAULT_SEED;
        end
        else if (seed_load)
        begin
            seed_reg <= pwdata;
        end
    end

    // Read back
    assign prdata = (paddr[2] == REG_SEED) ? seed_reg : '0;

    xrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    xrr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .seed_load    (seed_load),
        .seed_word    (pwdata),
        .low_bound    (req.low_bound),
        .high_bound   (req.high_bound),
        .raw_word     (rsp.raw_word),
        .ranged_value (rsp.ranged_value),
        .range_error  (rsp.range_error)
    );

endmodule
